[hw/rtl/rtu_pkg.sv]
// ----------------------------------------------------------------------------
// rtu_pkg: shared constants, types and functions for the RTU frame receiver
// Frame store geometry, operation and phase codes, CRC-16 fold.
// ----------------------------------------------------------------------------
package rtu_pkg;

    localparam int FRAME_BYTES = 256;
    localparam int ADDR_W      = $clog2(FRAME_BYTES);
    localparam int CNT_W       = $clog2(FRAME_BYTES + 1);
    localparam int BYTE_W      = 8;
    localparam int IDX_W       = 8;
    localparam int LEN_W       = 9;
    localparam int CRC_W       = 16;
    localparam int MIN_FRAME   = 5;

    localparam logic [CRC_W-1:0]  CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY = 16'hA001;
    localparam logic [BYTE_W-1:0] GAP_MAX  = 8'hFF;

    // operation codes
    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    // receiver phases
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_RECV = 2'd1;
    localparam logic [1:0] PH_DONE = 2'd2;
    localparam logic [1:0] PH_ERR  = 2'd3;

    // fault codes
    localparam logic [1:0] FAULT_NONE  = 2'd0;
    localparam logic [1:0] FAULT_SHORT = 2'd1;
    localparam logic [1:0] FAULT_CRC   = 2'd2;

    // configuration port
    localparam int         APB_ADDR_W      = 3;
    localparam int         APB_DATA_W      = 32;
    localparam logic       REG_GAP_TIMEOUT = 1'b0;
    localparam logic [7:0] GAP_TIMEOUT_RST = 8'd4;

    typedef struct packed {
        logic [1:0]        phase;
        logic [1:0]        error_kind;
        logic [BYTE_W-1:0] slave_address;
        logic [BYTE_W-1:0] function_byte;
        logic [LEN_W-1:0]  frame_length;
        logic [CRC_W-1:0]  trailer_crc;
    } t_result;

    // Fold one byte into a reflected CRC-16, one bit per step
    function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

[hw/rtl/rtu_if.sv]
// ----------------------------------------------------------------------------
// rtu_if: valid/ready channels of the RTU frame receiver
// Input operation channel and result channel.
// ----------------------------------------------------------------------------
interface rtu_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] rx_byte;
    logic [7:0] read_index;

    modport source (output valid, output opcode, output rx_byte, output read_index,
                    input ready);
    modport sink   (input valid, input opcode, input rx_byte, input read_index,
                    output ready);
endinterface

interface rtu_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  phase;
    logic [1:0]  error_kind;
    logic [7:0]  slave_address;
    logic [7:0]  function_byte;
    logic [8:0]  frame_length;
    logic [15:0] trailer_crc;
    logic [7:0]  read_data;

    modport source (output valid, output phase, output error_kind, output slave_address,
                    output function_byte, output frame_length, output trailer_crc,
                    output read_data, input ready);
    modport sink   (input valid, input phase, input error_kind, input slave_address,
                    input function_byte, input frame_length, input trailer_crc,
                    input read_data, output ready);
endinterface

[hw/rtl/rtu_frame_receiver_top.sv]
// ----------------------------------------------------------------------------
// rtu_frame_receiver_top: RTU frame receiver with silent-gap framing
// Stores received bytes, ends a frame on a tick-counted gap, checks CRC-16.
// ----------------------------------------------------------------------------
// Usage
//   i_in carries one operation word per handshake: a received byte, a
//   millisecond tick, a buffer read or a clear. o_out returns exactly one
//   status word per operation word, in order: phase, error kind, address and
//   function bytes, length, trailer and the read byte.
//   An accepted word passes the s1 register, then the output register,
//   before o_out.valid shows its result. One word is taken every cycle while
//   the result pipe has room; the frame state updates in the accepting cycle,
//   so the next word follows at once. The frame store is a synchronous RAM
//   with one write (byte store) and one read (buffer read) port; its
//   registered read sets the two-stage pipeline. Any one word writes or reads
//   the RAM, never both.
//   If the result side stalls, the result pipe (two words deep) fills and then
//   i_in.ready drops until o_out.ready returns; nothing is lost.
//   gap_timeout_ms sits at APB byte address 0; the user must write it only
//   while idle (unchecked). Reset (synchronous, active low) empties the pipe,
//   returns to idle with no stored bytes and sets the gap timeout to 4. The
//   store needs no clearing pass: reads past the stored length return zero.
// ----------------------------------------------------------------------------
module rtu_frame_receiver_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    rtu_in_if.sink                           i_in,
    rtu_out_if.source                        o_out,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rtu_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [rtu_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [rtu_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    // ---------------------------------------------------------------- config
    logic [7:0] r_gap_timeout;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_timeout <= rtu_pkg::GAP_TIMEOUT_RST;
        end else if (cfg_wr && paddr[2] == rtu_pkg::REG_GAP_TIMEOUT) begin
            r_gap_timeout <= pwdata[7:0];
        end
    end

    assign prdata = (paddr[2] == rtu_pkg::REG_GAP_TIMEOUT) ?
                    {{(rtu_pkg::APB_DATA_W-8){1'b0}}, r_gap_timeout} : '0;

    // ---------------------------------------------------------- frame state
    logic [1:0]                  r_phase, n_phase;
    logic [rtu_pkg::CNT_W-1:0]   r_count, n_count;
    logic [7:0]                  r_gap,   n_gap;
    logic [rtu_pkg::CRC_W-1:0]   r_crc,   n_crc;
    logic [1:0]                  r_fault, n_fault;
    // first two and last two stored bytes, kept beside the RAM
    logic [7:0]                  r_byte0, n_byte0;
    logic [7:0]                  r_byte1, n_byte1;
    logic [7:0]                  r_last0, n_last0;
    logic [7:0]                  r_last1, n_last1;

    logic                        in_acc;
    logic                        s1_move;
    logic                        store;
    logic                        rd_hit;
    logic [rtu_pkg::ADDR_W-1:0]  store_addr;
    logic [rtu_pkg::CRC_W-1:0]   crc_base;
    logic [7:0]                  gap_inc;
    logic                        trailer_ok;
    logic [7:0]                  ram_q;
    rtu_pkg::t_result            s0_res;

    // result pipe: s1 waits for the RAM read, out is the output register
    logic                        r_s1_valid;
    logic                        r_s1_rd;
    rtu_pkg::t_result            r_s1_res;
    logic                        r_out_valid;
    rtu_pkg::t_result            r_out_res;
    logic [7:0]                  r_out_rdata;

    assign s1_move    = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_s1_valid || s1_move;
    assign in_acc     = i_in.valid && i_in.ready;

    // idle restarts the frame at position zero
    assign store_addr = (r_phase == rtu_pkg::PH_IDLE) ? '0 : r_count[rtu_pkg::ADDR_W-1:0];
    assign crc_base   = (r_phase == rtu_pkg::PH_IDLE) ? rtu_pkg::CRC_INIT : r_crc;
    assign gap_inc    = (r_gap < rtu_pkg::GAP_MAX) ? r_gap + 8'd1 : r_gap;

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_gap   = r_gap;
        n_crc   = r_crc;
        n_fault = r_fault;
        store   = 1'b0;
        rd_hit  = 1'b0;
        unique case (i_in.opcode)
            rtu_pkg::OP_BYTE: begin
                if (r_phase == rtu_pkg::PH_IDLE) begin
                    store   = 1'b1;
                    n_phase = rtu_pkg::PH_RECV;
                    n_count = rtu_pkg::CNT_W'(1);
                    n_fault = rtu_pkg::FAULT_NONE;
                end else if (r_phase == rtu_pkg::PH_RECV &&
                             r_count < rtu_pkg::CNT_W'(rtu_pkg::FRAME_BYTES)) begin
                    store   = 1'b1;
                    n_count = r_count + rtu_pkg::CNT_W'(1);
                end
                if (store) begin
                    n_gap = '0;
                    n_crc = rtu_pkg::crc_fold(crc_base, i_in.rx_byte);
                end
            end
            rtu_pkg::OP_TICK: begin
                if (r_phase == rtu_pkg::PH_RECV) begin
                    n_gap = gap_inc;
                    if (gap_inc >= r_gap_timeout) begin
                        if (r_count < rtu_pkg::CNT_W'(rtu_pkg::MIN_FRAME)) begin
                            n_phase = rtu_pkg::PH_ERR;
                            n_fault = rtu_pkg::FAULT_SHORT;
                        end else if (r_crc == '0) begin
                            n_phase = rtu_pkg::PH_DONE;
                            n_fault = rtu_pkg::FAULT_NONE;
                        end else begin
                            n_phase = rtu_pkg::PH_ERR;
                            n_fault = rtu_pkg::FAULT_CRC;
                        end
                    end
                end
            end
            rtu_pkg::OP_READ: begin
                rd_hit = rtu_pkg::LEN_W'(i_in.read_index) < rtu_pkg::LEN_W'(r_count);
            end
            rtu_pkg::OP_CLEAR: begin
                n_phase = rtu_pkg::PH_IDLE;
                n_count = '0;
                n_gap   = '0;
                n_crc   = rtu_pkg::CRC_INIT;
                n_fault = rtu_pkg::FAULT_NONE;
            end
        endcase
    end

    always_comb begin
        n_byte0 = r_byte0;
        n_byte1 = r_byte1;
        n_last0 = r_last0;
        n_last1 = r_last1;
        if (store) begin
            if (store_addr == rtu_pkg::ADDR_W'(0)) begin
                n_byte0 = i_in.rx_byte;
            end
            if (store_addr == rtu_pkg::ADDR_W'(1)) begin
                n_byte1 = i_in.rx_byte;
            end
            n_last0 = r_last1;
            n_last1 = i_in.rx_byte;
        end
    end

    // snapshot of the state after this word
    assign trailer_ok = (n_phase == rtu_pkg::PH_DONE ||
                         (n_phase == rtu_pkg::PH_ERR && n_fault == rtu_pkg::FAULT_CRC)) &&
                        n_count >= rtu_pkg::CNT_W'(2);

    always_comb begin
        s0_res.phase         = n_phase;
        s0_res.error_kind    = n_fault;
        s0_res.slave_address = (n_count >= rtu_pkg::CNT_W'(1)) ? n_byte0 : 8'd0;
        s0_res.function_byte = (n_count >= rtu_pkg::CNT_W'(2)) ? n_byte1 : 8'd0;
        s0_res.frame_length  = rtu_pkg::LEN_W'(n_count);
        s0_res.trailer_crc   = trailer_ok ? {n_last1, n_last0} : 16'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= rtu_pkg::PH_IDLE;
            r_count <= '0;
            r_gap   <= '0;
            r_crc   <= rtu_pkg::CRC_INIT;
            r_fault <= rtu_pkg::FAULT_NONE;
        end else if (in_acc) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_gap   <= n_gap;
            r_crc   <= n_crc;
            r_fault <= n_fault;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_byte0 <= n_byte0;
            r_byte1 <= n_byte1;
            r_last0 <= n_last0;
            r_last1 <= n_last1;
        end
    end

    // ------------------------------------------------------------ frame RAM
    rtu_ram #(
        .WIDTH (8),
        .DEPTH (rtu_pkg::FRAME_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (in_acc && store),
        .i_waddr (store_addr),
        .i_wdata (i_in.rx_byte),
        .i_re    (in_acc && rd_hit),
        .i_raddr (i_in.read_index[rtu_pkg::ADDR_W-1:0]),
        .o_rdata (ram_q)
    );

    // ---------------------------------------------------------- result pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_s1_valid <= in_acc;
            end
            if (s1_move) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_res <= s0_res;
            r_s1_rd  <= rd_hit;
        end
        // RAM output holds while s1 waits: no read is issued without acceptance
        if (s1_move && r_s1_valid) begin
            r_out_res   <= r_s1_res;
            r_out_rdata <= r_s1_rd ? ram_q : 8'd0;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.phase         = r_out_res.phase;
    assign o_out.error_kind    = r_out_res.error_kind;
    assign o_out.slave_address = r_out_res.slave_address;
    assign o_out.function_byte = r_out_res.function_byte;
    assign o_out.frame_length  = r_out_res.frame_length;
    assign o_out.trailer_crc   = r_out_res.trailer_crc;
    assign o_out.read_data     = r_out_rdata;

    // ----------------------------------------------------------- assertions
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_move |=> r_s1_valid && $stable(r_s1_res))
        else $error("stalled result word lost or changed");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= rtu_pkg::CNT_W'(rtu_pkg::FRAME_BYTES))
        else $error("byte count beyond frame store");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == rtu_pkg::PH_IDLE |-> r_count == '0 && r_fault == rtu_pkg::FAULT_NONE)
        else $error("idle with stored bytes or fault");

    a_done_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_res.phase == rtu_pkg::PH_DONE |->
            r_out_res.frame_length >= rtu_pkg::LEN_W'(rtu_pkg::MIN_FRAME) &&
            r_out_res.error_kind == rtu_pkg::FAULT_NONE)
        else $error("complete frame too short or flagged");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(store && rd_hit))
        else $error("frame store written and read by one word");

endmodule

[hw/rtl/rtu_ram.sv]
// ----------------------------------------------------------------------------
// rtu_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rtu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
